/* design/sbh_pkg.sv */
// Shared types and constants for the streaming byte hash engine.
`default_nettype none

package sbh_pkg;

    localparam logic [1:0] MODE_CRC32 = 2'd0;
    localparam logic [1:0] MODE_FNV32 = 2'd1;
    localparam logic [1:0] MODE_FNV64 = 2'd2;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] FNV32_BASIS = 32'h811C_9DC5;
    localparam logic [63:0] FNV64_BASIS = 64'hCBF2_9CE4_8422_2325;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_message;
    } t_item;

    typedef struct packed {
        logic [63:0] next_hash;
        logic [63:0] final_hash;
    } t_hash_result;

endpackage

`default_nettype wire

/* design/sbh_absorb.sv */
// Combinational byte absorb and finish logic for CRC-32, FNV-1a 32 and FNV-1a 64.
`default_nettype none

module sbh_absorb (
    input  wire logic [1:0]          i_mode,
    input  wire logic [63:0]         i_running_hash,
    input  wire sbh_pkg::t_item      i_item,
    output sbh_pkg::t_hash_result    o_result
);

    logic [1:0]  eff_mode;
    logic [63:0] start_value;
    logic [63:0] base_hash;
    logic [31:0] crc_reg;
    logic [31:0] fnv32_x;
    logic [31:0] fnv32_p;
    logic [63:0] fnv64_x;
    logic [63:0] fnv64_p;
    logic [63:0] absorbed;
    logic [63:0] next_hash;

    always_comb begin
        unique case (i_mode)
            sbh_pkg::MODE_FNV32: eff_mode = sbh_pkg::MODE_FNV32;
            sbh_pkg::MODE_FNV64: eff_mode = sbh_pkg::MODE_FNV64;
            default:             eff_mode = sbh_pkg::MODE_CRC32;
        endcase
    end

    always_comb begin
        unique case (eff_mode)
            sbh_pkg::MODE_FNV32: start_value = {32'd0, sbh_pkg::FNV32_BASIS};
            sbh_pkg::MODE_FNV64: start_value = sbh_pkg::FNV64_BASIS;
            default:             start_value = {32'd0, sbh_pkg::CRC_INIT};
        endcase
    end

    assign base_hash = (i_item.first_byte || i_item.empty_message) ? start_value
                                                                   : i_running_hash;

    // Byte-wide reflected CRC, one shift per data bit.
    always_comb begin
        crc_reg = base_hash[31:0] ^ {24'd0, i_item.data_byte};
        for (int k = 0; k < 8; k++) begin
            if (crc_reg[0]) begin
                crc_reg = (crc_reg >> 1) ^ sbh_pkg::CRC_POLY;
            end else begin
                crc_reg = crc_reg >> 1;
            end
        end
    end

    // The FNV primes are sparse, so the multiplies reduce to shift-add trees.
    assign fnv32_x = base_hash[31:0] ^ {24'd0, i_item.data_byte};
    assign fnv32_p = (fnv32_x << 24) + (fnv32_x << 8) + (fnv32_x << 7)
                   + (fnv32_x << 4) + (fnv32_x << 1) + fnv32_x;

    assign fnv64_x = base_hash ^ {56'd0, i_item.data_byte};
    assign fnv64_p = (fnv64_x << 40) + (fnv64_x << 8) + (fnv64_x << 7)
                   + (fnv64_x << 5) + (fnv64_x << 4) + (fnv64_x << 1) + fnv64_x;

    always_comb begin
        unique case (eff_mode)
            sbh_pkg::MODE_FNV32: absorbed = {32'd0, fnv32_p};
            sbh_pkg::MODE_FNV64: absorbed = fnv64_p;
            default:             absorbed = {32'd0, crc_reg};
        endcase
    end

    assign next_hash = i_item.empty_message ? start_value : absorbed;

    always_comb begin
        o_result.next_hash = next_hash;
        unique case (eff_mode)
            sbh_pkg::MODE_FNV32: o_result.final_hash = {32'd0, next_hash[31:0]};
            sbh_pkg::MODE_FNV64: o_result.final_hash = next_hash;
            default:             o_result.final_hash = {32'd0, ~next_hash[31:0]};
        endcase
    end

endmodule

`default_nettype wire

/* design/streaming_byte_hash_engine.sv */
// Top level of the streaming byte hash engine with input and result registers.
// The last byte is registered first, then its final hash loads the result register.
// Throughput: one byte word per cycle unless the input is stalled.
// Only a word that ends a message waits for the result register to free up.
// Synchronous active-low reset clears the mode to CRC-32, the running hash to zero
// and both pipeline valid flags.
`default_nettype none

module streaming_byte_hash_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_empty_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_hash_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_hash_mode
);

    logic                  r_s1_valid;
    logic                  n_s1_valid;
    sbh_pkg::t_item        r_s1_item;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [63:0]           r_out_hash;
    logic [63:0]           r_running;
    logic [1:0]            r_mode;
    logic                  in_accept;
    logic                  out_free;
    logic                  s1_emits;
    logic                  s1_move;
    sbh_pkg::t_hash_result s1_result;

    sbh_absorb u_absorb (
        .i_mode         (r_mode),
        .i_running_hash (r_running),
        .i_item         (r_s1_item),
        .o_result       (s1_result)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign s1_emits  = r_s1_item.last_byte || r_s1_item.empty_message;
    assign s1_move   = r_s1_valid && (!s1_emits || out_free);
    assign o_stall   = r_s1_valid && !s1_move;
    assign in_accept = i_valid && !o_stall;

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;
    assign o_cfg_ready  = 1'b1;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_move && s1_emits) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_running   <= 64'd0;
            r_mode      <= sbh_pkg::MODE_CRC32;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_move) begin
                r_running <= s1_result.next_hash;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_hash_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.data_byte     <= i_data_byte;
            r_s1_item.first_byte    <= i_first_byte;
            r_s1_item.last_byte     <= i_last_byte;
            r_s1_item.empty_message <= i_empty_message;
        end
        if (s1_move && s1_emits) begin
            r_out_hash <= s1_result.final_hash;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && s1_emits && r_out_valid)
        else $error("Input stalled without a blocked message end in the input register.");

    a_mid_word_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_emits |-> !o_stall)
        else $error("A word that ends no message held up the input.");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && s1_emits |=> r_out_valid && o_hash_value == $past(s1_result.final_hash))
        else $error("A message end did not load the result register.");

endmodule

`default_nettype wire
